### src/sid_pkg.sv
package sid_pkg;

  // control bits that travel with each word down the divider pipeline
  typedef struct packed {
    logic valid;
    logic neg;
    logic zero_div;
  } sid_ctl_t;

endpackage

### src/sid_div_stage.sv
module sid_div_stage #(
  parameter int WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sid_pkg::sid_ctl_t   ctl_i,
  input  logic [WIDTH-1:0]    rem_i,
  input  logic [WIDTH-1:0]    qd_i,
  input  logic [WIDTH-1:0]    dvs_i,
  output sid_pkg::sid_ctl_t   ctl_o,
  output logic [WIDTH-1:0]    rem_o,
  output logic [WIDTH-1:0]    qd_o,
  output logic [WIDTH-1:0]    dvs_o
);
  import sid_pkg::*;

  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;
  logic             fits;
  sid_ctl_t         ctl_r;
  logic [WIDTH-1:0] rem_r, rem_nxt;
  logic [WIDTH-1:0] qd_r, qd_nxt;
  logic [WIDTH-1:0] dvs_r;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial   = {rem_i, qd_i[WIDTH-1]};
    diff    = trial - {1'b0, dvs_i};
    fits    = ~diff[WIDTH];
    rem_nxt = fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
    qd_nxt  = {qd_i[WIDTH-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= ctl_i.valid;
    end
    ctl_r.neg      <= ctl_i.neg;
    ctl_r.zero_div <= ctl_i.zero_div;
    rem_r          <= rem_nxt;
    qd_r           <= qd_nxt;
    dvs_r          <= dvs_i;
  end

  assign ctl_o = ctl_r;
  assign rem_o = rem_r;
  assign qd_o  = qd_r;
  assign dvs_o = dvs_r;

endmodule

### src/signed_int_divider.sv
// signed integer divider, quotient truncated toward zero
//
// input: a word is taken at a rising edge where start is high and busy is low;
//   in_numerator and in_denominator are two's complement values
// output: out_valid is high for exactly one cycle per word, together with
//   out_quotient, out_overflow and out_zero_divisor; the receiver cannot stall
// special cases: most negative by minus one gives the largest positive value
//   with out_overflow set; a zero divisor gives quotient zero with
//   out_zero_divisor set
// pipeline: one entry stage that takes magnitudes, one restoring subtract
//   stage per quotient bit, one sign fix-up stage
// throughput: one word per cycle while busy is low, since every quotient
//   bit has its own stage
// reset: synchronous; clears all valid bits, so words in flight are dropped;
//   busy is registered, set during reset and cleared once reset is released
module signed_int_divider #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] in_numerator,
  input  logic signed [DATA_WIDTH-1:0] in_denominator,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] out_quotient,
  output logic                         out_overflow,
  output logic                         out_zero_divisor
);
  import sid_pkg::*;

  localparam int LATENCY = DATA_WIDTH + 2;
  localparam logic [DATA_WIDTH-1:0] MaxPos = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  logic                  busy_r;
  logic                  accept;
  logic [DATA_WIDTH-1:0] num_mag, den_mag;

  sid_ctl_t              ctl_s [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] rem_s [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] qd_s  [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] dvs_s [0:DATA_WIDTH];

  sid_ctl_t              ctl_r;
  logic [DATA_WIDTH-1:0] mag_n_r, mag_d_r;

  logic                  out_valid_r;
  logic [DATA_WIDTH-1:0] quot_r, quot_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  zdiv_r, zdiv_nxt;
  logic [DATA_WIDTH-1:0] q_mag;
  sid_ctl_t              ctl_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start & ~busy_r;

  // entry stage: signs, zero check, magnitudes
  always_comb begin
    num_mag = in_numerator[DATA_WIDTH-1] ? (~in_numerator + 1'b1) : in_numerator;
    den_mag = in_denominator[DATA_WIDTH-1] ? (~in_denominator + 1'b1) : in_denominator;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= accept;
    end
    ctl_r.neg      <= in_numerator[DATA_WIDTH-1] ^ in_denominator[DATA_WIDTH-1];
    ctl_r.zero_div <= (in_denominator == '0);
    mag_n_r        <= num_mag;
    mag_d_r        <= den_mag;
  end

  assign ctl_s[0] = ctl_r;
  assign rem_s[0] = '0;
  assign qd_s[0]  = mag_n_r;
  assign dvs_s[0] = mag_d_r;

  // one quotient bit per stage, most significant first
  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_step
    sid_div_stage #(
      .WIDTH (DATA_WIDTH)
    ) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (ctl_s[i]),
      .rem_i (rem_s[i]),
      .qd_i  (qd_s[i]),
      .dvs_i (dvs_s[i]),
      .ctl_o (ctl_s[i+1]),
      .rem_o (rem_s[i+1]),
      .qd_o  (qd_s[i+1]),
      .dvs_o (dvs_s[i+1])
    );
  end

  assign ctl_last = ctl_s[DATA_WIDTH];
  assign q_mag    = qd_s[DATA_WIDTH];

  // sign fix-up, saturation and zero divisor handling
  always_comb begin
    quot_nxt = q_mag;
    ovf_nxt  = 1'b0;
    zdiv_nxt = 1'b0;
    if (ctl_last.zero_div) begin
      quot_nxt = '0;
      zdiv_nxt = 1'b1;
    end else if (!ctl_last.neg && q_mag[DATA_WIDTH-1]) begin
      quot_nxt = MaxPos;
      ovf_nxt  = 1'b1;
    end else if (ctl_last.neg) begin
      quot_nxt = ~q_mag + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl_last.valid;
    end
  end

  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
    ovf_r  <= ovf_nxt;
    zdiv_r <= zdiv_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_quotient     = quot_r;
  assign out_overflow     = ovf_r;
  assign out_zero_divisor = zdiv_r;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("word accepted but no result after pipeline latency");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_overflow && out_zero_divisor))
    else $error("overflow and zero divisor flagged together");

  a_zero_div_quot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_divisor) |-> (out_quotient == '0))
    else $error("zero divisor result with nonzero quotient");

  a_ovf_quot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |-> (out_quotient == MaxPos))
    else $error("overflow result not saturated");

  a_busy_after_reset: assert property (@(posedge clk)
    !rst_n |=> busy)
    else $error("busy low right after reset");
`endif

endmodule
